// ----- rtl/core/hpd_pkg.sv -----
// Shared types and constants of the Hall sensor peak detector.
package hpd_pkg;

   // Register field widths
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int MC_W       = 12;
   localparam int AMP_W      = 12;
   localparam int REF_W      = 16;
   localparam int TIME_W     = 32;
   localparam int CNT_W      = 4;

   // Register reset values
   localparam logic [MC_W-1:0]  MIN_CHANGE_RST    = MC_W'(30);
   localparam logic [AMP_W-1:0] MIN_AMPLITUDE_RST = AMP_W'(200);
   localparam logic [REF_W-1:0] REF_NORMAL_RST    = REF_W'(200);
   localparam logic [REF_W-1:0] REF_CALIB_RST     = REF_W'(100);

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_CHANGE    = 3'd0,
      CSR_MIN_AMPLITUDE = 3'd1,
      CSR_REF_NORMAL    = 3'd2,
      CSR_REF_CALIB     = 3'd3
   } csr_index_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the incoming word
      logic prime;     // first sample: seed history and baseline
      logic detect;    // peak test and refractory update
      logic mul;       // form baseline * count + sample
      logic div_step;  // one restoring division step
      logic settle;    // write new baseline, shift history
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic primed;
      logic settling;
      logic div_last;
   } status_type;

endpackage

// ----- rtl/core/hpd_ctrl.sv -----
// Sequencer of the Hall sensor peak detector: handshakes and datapath commands.
module hpd_ctrl
   import hpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_DIV,
      ST_SETTLE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      out_free;
   logic      load_rsp;

   // Output register can take a new word this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.primed && status.settling) begin
               state_in = ST_MUL;
            end else if (out_free) begin
               cmd.prime  = !status.primed;
               cmd.detect = status.primed;
               state_in   = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            if (out_free) begin
               cmd.settle = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign load_rsp  = cmd.prime || cmd.detect || cmd.settle;
   assign rsp_valid = rsp_valid_ff;

   // State and result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ----- rtl/core/hpd_datapath.sv -----
// Datapath of the Hall sensor peak detector: registers, history, divider, peak test.
module hpd_datapath
   import hpd_pkg::*;
#(
   parameter int SETTLE_SAMPLES = 10,
   parameter int SAMPLE_BITS    = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_calib_mode,
   input  logic [TIME_W-1:0]      req_now_ms,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   rsp_peak_flag
);

   localparam int NUM_W     = SAMPLE_BITS + CNT_W;
   localparam int DIV_CNT_W = $clog2(NUM_W);
   localparam int CMP_W     = ((SAMPLE_BITS > MC_W) ? SAMPLE_BITS : MC_W) + 2;

   // Configuration registers
   logic [MC_W-1:0]  min_change_ff;
   logic [AMP_W-1:0] min_amp_ff;
   logic [REF_W-1:0] ref_normal_ff;
   logic [REF_W-1:0] ref_calib_ff;

   // Captured word
   logic [SAMPLE_BITS-1:0] smp_ff;
   logic                   calib_ff;
   logic [TIME_W-1:0]      now_ff;

   // Detector state
   logic                   primed_ff,  primed_in;
   logic [SAMPLE_BITS-1:0] last_ff,    last_in;
   logic [SAMPLE_BITS-1:0] older_ff,   older_in;
   logic [SAMPLE_BITS-1:0] base_ff,    base_in;
   logic [CNT_W-1:0]       cnt_ff,     cnt_in;
   logic                   in_ref_ff,  in_ref_in;
   logic [TIME_W-1:0]      pk_time_ff, pk_time_in;
   logic                   peak_ff,    peak_in;

   // Divider state: numerator shifts out, quotient shifts in
   logic [NUM_W-1:0]     num_ff,     num_in;
   logic [CNT_W-1:0]     rem_ff,     rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic [NUM_W-1:0]         prod;
   logic [CNT_W:0]           rem_shift;
   logic [CNT_W:0]           divisor;
   logic                     div_ge;
   logic [CNT_W:0]           rem_diff;

   logic signed [CMP_W-1:0]  s_x, last_x, older_x, base_x, mc_x, amp_x;
   logic signed [CMP_W-1:0]  chg_now, chg_prev, base_diff, dist_abs;
   logic                     peak_hit;
   logic [REF_W-1:0]         interval;
   logic [TIME_W-1:0]        elapsed;
   logic                     expired;

   // Multiply for the running mean numerator
   assign prod = NUM_W'(base_ff) * NUM_W'(cnt_ff);

   // One restoring division step
   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign divisor   = {1'b0, cnt_ff} + (CNT_W+1)'(1);
   assign div_ge    = (rem_shift >= divisor);
   assign rem_diff  = rem_shift - divisor;

   // Signed differences for the peak test
   assign s_x       = $signed(CMP_W'(smp_ff));
   assign last_x    = $signed(CMP_W'(last_ff));
   assign older_x   = $signed(CMP_W'(older_ff));
   assign base_x    = $signed(CMP_W'(base_ff));
   assign mc_x      = $signed(CMP_W'(min_change_ff));
   assign amp_x     = $signed(CMP_W'(min_amp_ff));
   assign chg_now   = s_x - last_x;
   assign chg_prev  = last_x - older_x;
   assign base_diff = s_x - base_x;
   assign dist_abs  = base_diff[CMP_W-1] ? -base_diff : base_diff;
   assign peak_hit  = (chg_prev > mc_x) && (chg_now < -mc_x) && (dist_abs > amp_x);

   // Refractory timing, wraps modulo 2^32
   assign interval = calib_ff ? ref_calib_ff : ref_normal_ff;
   assign elapsed  = now_ff - pk_time_ff;
   assign expired  = elapsed > TIME_W'(interval);

   // Next values of state
   always_comb begin
      primed_in  = primed_ff;
      last_in    = last_ff;
      older_in   = older_ff;
      base_in    = base_ff;
      cnt_in     = cnt_ff;
      in_ref_in  = in_ref_ff;
      pk_time_in = pk_time_ff;
      peak_in    = peak_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.prime) begin
         primed_in = 1'b1;
         last_in   = smp_ff;
         older_in  = smp_ff;
         base_in   = smp_ff;
         cnt_in    = '0;
         peak_in   = 1'b0;
      end
      if (cmd.mul) begin
         num_in     = prod + NUM_W'(smp_ff);
         rem_in     = '0;
         div_cnt_in = '0;
      end
      if (cmd.div_step) begin
         num_in     = {num_ff[NUM_W-2:0], div_ge};
         rem_in     = div_ge ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.settle) begin
         base_in  = num_ff[SAMPLE_BITS-1:0];
         older_in = last_ff;
         last_in  = smp_ff;
         cnt_in   = cnt_ff + CNT_W'(1);
         peak_in  = 1'b0;
      end
      if (cmd.detect) begin
         older_in = last_ff;
         last_in  = smp_ff;
         peak_in  = 1'b0;
         if (!in_ref_ff) begin
            if (peak_hit) begin
               peak_in    = 1'b1;
               in_ref_in  = 1'b1;
               pk_time_in = now_ff;
            end
         end else if (expired) begin
            in_ref_in = 1'b0;
         end
      end
   end

   // Configuration and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         min_change_ff <= MIN_CHANGE_RST;
         min_amp_ff    <= MIN_AMPLITUDE_RST;
         ref_normal_ff <= REF_NORMAL_RST;
         ref_calib_ff  <= REF_CALIB_RST;
         primed_ff     <= 1'b0;
         cnt_ff        <= '0;
         in_ref_ff     <= 1'b0;
         last_ff       <= '0;
         older_ff      <= '0;
         base_ff       <= '0;
         pk_time_ff    <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_MIN_CHANGE:    min_change_ff <= csr_wdata[MC_W-1:0];
               CSR_MIN_AMPLITUDE: min_amp_ff    <= csr_wdata[AMP_W-1:0];
               CSR_REF_NORMAL:    ref_normal_ff <= csr_wdata[REF_W-1:0];
               CSR_REF_CALIB:     ref_calib_ff  <= csr_wdata[REF_W-1:0];
               default: ;
            endcase
         end
         primed_ff  <= primed_in;
         cnt_ff     <= cnt_in;
         in_ref_ff  <= in_ref_in;
         last_ff    <= last_in;
         older_ff   <= older_in;
         base_ff    <= base_in;
         pk_time_ff <= pk_time_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         smp_ff   <= req_sample;
         calib_ff <= req_calib_mode;
         now_ff   <= req_now_ms;
      end
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      peak_ff    <= peak_in;
   end

   assign status.primed   = primed_ff;
   assign status.settling = (cnt_ff < CNT_W'(SETTLE_SAMPLES));
   assign status.div_last = (div_cnt_ff == DIV_CNT_W'(NUM_W - 1));
   assign rsp_peak_flag   = peak_ff;

endmodule

// ----- rtl/core/hall_peak_detector.sv -----
// Priming and detection words are evaluated in the state after the accept, and the result
// is registered; settling words first pass the multiply, the bit-serial mean divider and
// the settle state. Evaluation and settling wait while an earlier result is still held;
// one word is processed at a time and a waiting result does not block the next accept.
// Reset: synchronous, active high; thresholds return to their defaults, history and
// baseline clear, and the next word primes the detector.
module hall_peak_detector
   import hpd_pkg::*;
#(
   parameter int SETTLE_SAMPLES = 10,
   parameter int SAMPLE_BITS    = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_calib_mode,
   input  logic [TIME_W-1:0]      req_now_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_peak_flag
);

   cmd_type    cmd;
   status_type status;

   // Sequencer
   hpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   hpd_datapath #(
      .SETTLE_SAMPLES (SETTLE_SAMPLES),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_sample     (req_sample),
      .req_calib_mode (req_calib_mode),
      .req_now_ms     (req_now_ms),
      .cmd            (cmd),
      .status         (status),
      .rsp_peak_flag  (rsp_peak_flag)
   );

endmodule

// ----- rtl/core/hpd_checker.sv -----
// Port-level checks of the Hall sensor peak detector and their bind.
module hpd_port_props (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_peak_flag
);

   logic       req_acc;
   logic       rsp_acc;
   logic [1:0] pend_ff;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // Words accepted but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 2'(req_acc) - 2'(rsp_acc);
      end
   end

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_peak_flag))
      else $error("result dropped or changed while stalled");

   // One word at a time: busy in the cycle after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("word accepted while previous one still in work");

   // After reset the block is idle and ready
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   // No result without an accepted word
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result shown with no word outstanding");

   // At most one word in work and one waiting
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many words outstanding");

endmodule

bind hall_peak_detector hpd_port_props u_hpd_port_props (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_peak_flag (rsp_peak_flag)
);

// ----- test/hpd_checker.sv -----
// Checker for the Hall sensor peak detector: predicts each result word and compares.
`timescale 1ns / 1ps

module hpd_checker
   import hpd_pkg::*;
#(
   parameter int SETTLE_SAMPLES = 10,
   parameter int SAMPLE_BITS    = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_calib_mode,
   input  logic [TIME_W-1:0]      req_now_ms,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   rsp_peak_flag,
   output int                     fail_count,
   output int                     pending,
   output int                     checked,
   output int                     peak_total
);

   typedef struct {
      logic peak;
      int   word_no;
   } peak_entry_type;

   // Thresholds as last written
   logic [MC_W-1:0]  mc_thr;
   logic [AMP_W-1:0] amp_thr;
   logic [REF_W-1:0] normal_ivl;
   logic [REF_W-1:0] calib_ivl;

   // Detector history
   logic                   primed;
   logic [SAMPLE_BITS-1:0] last_smp;
   logic [SAMPLE_BITS-1:0] older_smp;
   logic [SAMPLE_BITS-1:0] baseline;
   int                     settle_cnt;
   logic                   refractory;
   logic [TIME_W-1:0]      peak_stamp;

   peak_entry_type peak_q[$];
   int             words_in;

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      fail_count++;
   endtask

   // Advances the detector by one sample; returns the peak flag for that sample
   function automatic logic step_detector(input logic [SAMPLE_BITS-1:0] smp,
                                          input logic calib,
                                          input logic [TIME_W-1:0] now);
      int               smp_i;
      int               last_i;
      int               older_i;
      int               base_i;
      int               rise_now;
      int               rise_prev;
      int               dist_mag;
      int               mc_i;
      int               amp_i;
      logic [REF_W-1:0] ivl;
      logic [TIME_W-1:0] elapsed;
      logic             hit;

      hit = 1'b0;
      smp_i = smp;
      last_i = last_smp;
      older_i = older_smp;
      base_i = baseline;

      // first word after reset seeds everything
      if (!primed) begin
         primed = 1'b1;
         last_smp = smp;
         older_smp = smp;
         baseline = smp;
         settle_cnt = 0;
         return 1'b0;
      end

      // running mean, truncated at every step
      if (settle_cnt < SETTLE_SAMPLES) begin
         base_i = (base_i * settle_cnt + smp_i) / (settle_cnt + 1);
         baseline = base_i[SAMPLE_BITS-1:0];
         older_smp = last_smp;
         last_smp = smp;
         settle_cnt++;
         return 1'b0;
      end

      rise_now = smp_i - last_i;
      rise_prev = last_i - older_i;
      dist_mag = smp_i - base_i;
      if (dist_mag < 0) dist_mag = -dist_mag;
      mc_i = mc_thr;
      amp_i = amp_thr;
      ivl = calib ? calib_ivl : normal_ivl;

      if (!refractory && rise_prev > mc_i && rise_now < -mc_i && dist_mag > amp_i) begin
         hit = 1'b1;
         refractory = 1'b1;
         peak_stamp = now;
      end

      // elapsed time wraps modulo 2^32
      elapsed = now - peak_stamp;
      if (refractory && elapsed > ivl) refractory = 1'b0;

      older_smp = last_smp;
      last_smp = smp;
      return hit;
   endfunction

   always @(posedge clock) begin : monitor
      peak_entry_type ent;

      if (reset) begin
         mc_thr = MIN_CHANGE_RST;
         amp_thr = MIN_AMPLITUDE_RST;
         normal_ivl = REF_NORMAL_RST;
         calib_ivl = REF_CALIB_RST;
         primed = 1'b0;
         last_smp = '0;
         older_smp = '0;
         baseline = '0;
         settle_cnt = 0;
         refractory = 1'b0;
         peak_stamp = '0;
         peak_q.delete();
         words_in = 0;
      end else begin
         // register writes; unknown indexes fall through
         if (csr_write) begin
            case (csr_index)
               CSR_MIN_CHANGE:    mc_thr = csr_wdata[MC_W-1:0];
               CSR_MIN_AMPLITUDE: amp_thr = csr_wdata[AMP_W-1:0];
               CSR_REF_NORMAL:    normal_ivl = csr_wdata[REF_W-1:0];
               CSR_REF_CALIB:     calib_ivl = csr_wdata[REF_W-1:0];
               default: ;
            endcase
         end

         // result side first, so a word accepted this edge is not matched yet
         if (rsp_valid && rsp_ready) begin
            if (peak_q.size() == 0) begin
               report_mismatch($sformatf("result word (peak flag=%b) with none outstanding",
                                         rsp_peak_flag));
            end else begin
               ent = peak_q.pop_front();
               checked++;
               if (rsp_peak_flag !== ent.peak)
                  report_mismatch($sformatf("sample word %0d: peak flag=%b, predicted %b",
                                            ent.word_no, rsp_peak_flag, ent.peak));
            end
         end

         if (req_valid && req_ready) begin
            ent.peak = step_detector(req_sample, req_calib_mode, req_now_ms);
            ent.word_no = words_in;
            words_in++;
            if (ent.peak) peak_total++;
            peak_q.push_back(ent);
         end
      end
      pending <= peak_q.size();
   end

endmodule

// ----- test/tb.sv -----
// Testbench top for the Hall sensor peak detector: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb;
   import hpd_pkg::*;

   localparam int SETTLE_SAMPLES = 10;
   localparam int SAMPLE_BITS    = 12;
   localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
   localparam int SETTLED_LEVEL  = 2045;  // baseline left by the directed settling words
   localparam int DRAIN_CYCLES   = 32;
   localparam int QUIET_LIMIT    = 3000;
   localparam int PHASES         = 7;
   localparam int RANDOM_WORDS   = 1825;

   // receiver stall patterns
   localparam int RX_OPEN    = 0;
   localparam int RX_PATTERN = 1;
   localparam int RX_RANDOM  = 2;
   localparam int RX_LONG    = 3;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_BITS-1:0] req_sample = '0;
   logic                   req_calib_mode = 1'b0;
   logic [TIME_W-1:0]      req_now_ms = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_peak_flag;

   int fail_count;
   int pending;
   int checked;
   int peak_total;

   // stimulus state
   int          burst_left = 0;
   bit          tx_idle = 1'b1;
   int          rx_mode = RX_OPEN;
   int          rx_tick = 0;
   int          quiet = 0;
   logic [31:0] clock_ms = '0;
   int          mc_cur = 30;
   int          amp_cur = 200;
   int          rn_cur = 200;
   int          rc_cur = 100;

   hall_peak_detector #(
      .SETTLE_SAMPLES(SETTLE_SAMPLES),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_top (.*);

   hpd_checker #(
      .SETTLE_SAMPLES(SETTLE_SAMPLES),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rx_tick <= rx_tick + 1;
      case (rx_mode)
         RX_OPEN:    rsp_ready <= 1'b1;
         RX_PATTERN: rsp_ready <= (rx_tick % 7) < 4;
         RX_RANDOM:  rsp_ready <= $urandom_range(0, 3) != 0;
         RX_LONG:    rsp_ready <= (rx_tick % 32) >= 20;
         default:    rsp_ready <= 1'b1;
      endcase
   end

   // watchdog: too long without any word moving
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [SAMPLE_BITS-1:0] clamp_level(input int v);
      if (v < 0) return '0;
      if (v > SAMPLE_MAX) return SAMPLE_MAX[SAMPLE_BITS-1:0];
      return v[SAMPLE_BITS-1:0];
   endfunction

   // one sample word, with bursty sender gaps
   task automatic send_word(input logic [SAMPLE_BITS-1:0] smp, input logic calib,
                            input logic [31:0] stamp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = 0;
         if (tx_idle)
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_sample <= smp;
      req_calib_mode <= calib;
      req_now_ms <= stamp;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and let every outstanding result come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // new thresholds; upper bits of the 12-bit fields carry junk
   task automatic apply_settings(input int mc, input int amp, input int rn, input int rc);
      hold_until_drained();
      write_reg(CSR_IDX_W'($urandom_range(2 ** CSR_IDX_W - 1, CSR_REF_CALIB + 1)),
                CSR_DATA_W'($urandom));
      write_reg(CSR_MIN_CHANGE, {4'($urandom), 12'(mc)});
      write_reg(CSR_MIN_AMPLITUDE, {4'($urandom), 12'(amp)});
      write_reg(CSR_REF_NORMAL, 16'(rn));
      write_reg(CSR_REF_CALIB, 16'(rc));
      csr_write <= 1'b0;
      @(posedge clock);
      mc_cur = mc;
      amp_cur = amp;
      rn_cur = rn;
      rc_cur = rc;
   endtask

   // timestamp steps around the refractory boundary, plus the odd wild jump
   task automatic advance_clock(input logic calib);
      int ivl;
      ivl = calib ? rc_cur : rn_cur;
      case ($urandom_range(0, 7))
         0:       ;
         1, 2:    clock_ms += $urandom_range(1, 20);
         3:       clock_ms += $urandom_range(0, ivl / 2);
         4:       clock_ms += ivl;
         5:       clock_ms += ivl + 1;
         6:       clock_ms += ivl + $urandom_range(2, 50);
         default: clock_ms = $urandom;
      endcase
   endtask

   task automatic random_word(input int level);
      logic calib;
      calib = 1'($urandom_range(0, 1));
      advance_clock(calib);
      send_word(clamp_level(level), calib, clock_ms);
   endtask

   function automatic int pick_slope();
      case ($urandom_range(0, 4))
         0:       return mc_cur;
         1:       return mc_cur + 1;
         2:       return $urandom_range(0, 2 * mc_cur + 64);
         3:       return $urandom_range(mc_cur + 1, mc_cur + 600);
         default: return $urandom_range(0, SAMPLE_MAX);
      endcase
   endfunction

   // rise then fall, ending on a level near the amplitude threshold or anywhere in the range
   task automatic shape_peak();
      int tail_lvl;
      int rise;
      int fall;
      case ($urandom_range(0, 5))
         0:       tail_lvl = SETTLED_LEVEL + amp_cur;
         1:       tail_lvl = SETTLED_LEVEL + amp_cur + 1;
         2:       tail_lvl = SETTLED_LEVEL - amp_cur - 1;
         default: tail_lvl = $urandom_range(0, SAMPLE_MAX);
      endcase
      rise = pick_slope();
      fall = pick_slope();
      random_word(tail_lvl + fall - rise);
      random_word(tail_lvl + fall);
      random_word(tail_lvl);
   endtask

   task automatic run_phase(input int n_words);
      int done;
      int k;
      int level;
      done = 0;
      while (done < n_words) begin
         k = $urandom_range(0, 9);
         if (k < 7) begin
            shape_peak();
            done += 3;
         end else if (k < 9) begin
            random_word($urandom_range(0, SAMPLE_MAX));
            done++;
         end else begin
            // flat stretch: zero slope
            level = $urandom_range(0, SAMPLE_MAX);
            repeat (4) random_word(level);
            done += 4;
         end
         if ($urandom_range(0, 149) == 0) hold_until_drained();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // priming and settling with the extremes of the sample range
      send_word(12'd4095, 1'b0, 32'd0);
      send_word(12'd0,    1'b1, 32'd10);
      send_word(12'd4095, 1'b0, 32'd20);
      send_word(12'd0,    1'b0, 32'd30);
      send_word(12'd4095, 1'b1, 32'd40);
      send_word(12'd1,    1'b0, 32'd50);
      send_word(12'd4094, 1'b0, 32'd60);
      send_word(12'd2048, 1'b0, 32'd70);
      send_word(12'd2047, 1'b0, 32'd80);
      send_word(12'd4095, 1'b0, 32'd90);
      send_word(12'd0,    1'b0, 32'd100);
      // first peak, then one masked by refractory
      send_word(12'd3000, 1'b0, 32'd1000);
      send_word(12'd3500, 1'b0, 32'd1010);
      send_word(12'd3400, 1'b0, 32'd1020);
      send_word(12'd3600, 1'b0, 32'd1100);
      send_word(12'd3500, 1'b0, 32'd1110);
      // switch to calibration mode mid-refractory, which ends it early
      send_word(12'd3700, 1'b1, 32'd1121);
      send_word(12'd3600, 1'b1, 32'd1130);
      // interval boundary: equal keeps refractory, one past ends it after the test
      send_word(12'd3700, 1'b0, 32'd1330);
      send_word(12'd3600, 1'b0, 32'd1331);
      send_word(12'd3700, 1'b0, 32'd1340);
      // peak just before the timestamp wraps, refractory ends across the wrap
      send_word(12'd3600, 1'b0, 32'hFFFF_FFF0);
      send_word(12'd3700, 1'b0, 32'h0000_00C8);
      send_word(12'd3600, 1'b0, 32'h0000_00D0);
      // rise exactly at the change threshold is not enough
      send_word(12'd3630, 1'b0, 32'h0000_1000);
      send_word(12'd3599, 1'b0, 32'h0000_1010);
      clock_ms = 32'h0000_1010;

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: apply_settings(0, 0, 65535, 0);
            1: apply_settings(4095, 4095, 0, 65535);
            2: apply_settings($urandom_range(0, 64), $urandom_range(0, 400),
                              $urandom_range(0, 300), $urandom_range(0, 300));
            default: apply_settings($urandom_range(0, 300), $urandom_range(0, 1500),
                                    $urandom_range(0, 2000), $urandom_range(0, 2000));
         endcase
         rx_mode <= p % 4;
         tx_idle = (p != 0);
         if (p == 2) clock_ms = 32'hFFFF_FF00;
         run_phase(RANDOM_WORDS / PHASES);
      end
      hold_until_drained();

      $display("Run summary: %0d result words checked across %0d threshold settings,",
               checked, PHASES + 1);
      $display("  %0d of them peaks, with timestamp wraps and all receiver stall patterns.",
               peak_total);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
